>>> hw/rtl/psft_pkg.sv
// Shared types, codes and constants of the publish/subscribe fan-out table.
package psft_pkg;

  localparam int PRODUCER_SLOTS_DEF   = 16;
  localparam int SUBSCRIBER_SLOTS_DEF = 32;
  localparam int MAX_RESULTS          = 32;
  localparam int CNT_W                = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] CMD_REG_PROD  = 3'd0;
  localparam logic [2:0] CMD_REG_CONS  = 3'd1;
  localparam logic [2:0] CMD_SUBSCRIBE = 3'd2;
  localparam logic [2:0] CMD_UNSUB     = 3'd3;
  localparam logic [2:0] CMD_NOTIFY    = 3'd4;
  localparam logic [2:0] CMD_LIST_PROD = 3'd5;
  localparam logic [2:0] CMD_LIST_SUB  = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN   = 3'd7;

  localparam logic [2:0] KIND_ACK  = 3'd0;
  localparam logic [2:0] KIND_NACK = 3'd1;
  localparam logic [2:0] KIND_NOTE = 3'd2;
  localparam logic [2:0] KIND_PROD = 3'd3;
  localparam logic [2:0] KIND_SUB  = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] client_id;
    logic [15:0] category;
    logic [15:0] reply_queue;
    logic [31:0] message_handle;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] dest_queue;
    logic [15:0] entry_client;
    logic [15:0] entry_category;
    logic [31:0] payload_tag;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] owner;
    logic [15:0] category;
  } prod_entry_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] client;
    logic [15:0] category;
    logic [15:0] queue;
  } sub_entry_t;

  localparam int PROD_W = $bits(prod_entry_t);
  localparam int SUB_W  = $bits(sub_entry_t);

endpackage

>>> hw/rtl/psft_ram.sv
// Single-port synchronous table memory with registered, enabled read.
module psft_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/psft_out.sv
// Result output register between the sequencer and the result channel.
module psft_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psft_pkg::out_res_t  res_in,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output psft_pkg::out_res_t  out_res
);

  logic               valid_r;
  psft_pkg::out_res_t data_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

>>> hw/rtl/psft_seq.sv
// Request sequencer: clears the tables, scans them, writes back and emits results.
module psft_seq #(
  parameter int P   = psft_pkg::PRODUCER_SLOTS_DEF,
  parameter int S   = psft_pkg::SUBSCRIBER_SLOTS_DEF,
  parameter int PAW = 4,
  parameter int SAW = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  psft_pkg::in_req_t           in_req,
  output logic                        prod_rd_en,
  output logic                        prod_we,
  output logic [PAW-1:0]              prod_addr,
  output logic [psft_pkg::PROD_W-1:0] prod_wdata,
  input  logic [psft_pkg::PROD_W-1:0] prod_rdata,
  output logic                        sub_rd_en,
  output logic                        sub_we,
  output logic [SAW-1:0]              sub_addr,
  output logic [psft_pkg::SUB_W-1:0]  sub_wdata,
  input  logic [psft_pkg::SUB_W-1:0]  sub_rdata,
  input  logic                        res_free,
  output logic                        res_push,
  output psft_pkg::out_res_t          res_data
);

  localparam int MAXN = (P > S) ? P : S;
  localparam int IW   = $clog2(MAXN + 1);
  localparam int CW   = psft_pkg::CNT_W;

  localparam logic [IW-1:0] P_N      = IW'(P);
  localparam logic [IW-1:0] S_N      = IW'(S);
  localparam logic [IW-1:0] LAST_CLR = IW'(MAXN - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(psft_pkg::MAX_RESULTS);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  psft_pkg::in_req_t   req_r, req_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                found_r, found_nxt;
  logic                dup_r, dup_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pend_v_r, pend_v_nxt;
  psft_pkg::out_res_t  pend_r, pend_nxt;

  psft_pkg::prod_entry_t pe;
  psft_pkg::sub_entry_t  se;
  psft_pkg::prod_entry_t pw;
  psft_pkg::sub_entry_t  sw;
  psft_pkg::out_res_t    emit_res;
  psft_pkg::out_res_t    fin_res;

  logic          use_prod;
  logic [IW-1:0] scan_n;
  logic          stop;
  logic          eval;
  logic          hit_emit;
  logic          stall;
  logic          issue;
  logic          scan_done;
  logic          fin_has;
  logic          fin_go;
  logic          cmd_takes_scan;

  assign pe = psft_pkg::prod_entry_t'(prod_rdata);
  assign se = psft_pkg::sub_entry_t'(sub_rdata);

  assign use_prod = (req_r.command == psft_pkg::CMD_REG_PROD) ||
                    (req_r.command == psft_pkg::CMD_LIST_PROD);
  assign scan_n   = use_prod ? P_N : S_N;
  assign stop     = (((req_r.command == psft_pkg::CMD_SUBSCRIBE) ||
                      (req_r.command == psft_pkg::CMD_UNSUB)) && found_r) ||
                    (cnt_r == MAX_CNT);
  assign eval     = (state_r == ST_SCAN) && chk_v_r && !stop;

  always_comb begin
    hit_emit = 1'b0;
    emit_res = '0;
    emit_res.dest_queue     = req_r.reply_queue;
    emit_res.entry_client   = req_r.client_id;
    emit_res.entry_category = req_r.category;
    case (req_r.command)
      psft_pkg::CMD_NOTIFY: begin
        hit_emit                = se.valid && (se.category == req_r.category);
        emit_res.kind           = psft_pkg::KIND_NOTE;
        emit_res.dest_queue     = se.queue;
        emit_res.payload_tag    = req_r.message_handle;
      end
      psft_pkg::CMD_LIST_PROD: begin
        hit_emit                = pe.valid;
        emit_res.kind           = psft_pkg::KIND_PROD;
        emit_res.entry_client   = pe.owner;
        emit_res.entry_category = pe.category;
      end
      psft_pkg::CMD_LIST_SUB: begin
        hit_emit                = se.valid && (se.client == req_r.client_id);
        emit_res.kind           = psft_pkg::KIND_SUB;
        emit_res.entry_category = se.category;
      end
      default: begin
        hit_emit = 1'b0;
      end
    endcase
  end

  assign stall     = eval && hit_emit && pend_v_r && !res_free;
  assign issue     = (state_r == ST_SCAN) && !stall && !stop && (idx_r != scan_n);
  assign scan_done = stop || ((idx_r == scan_n) && !chk_v_r);

  always_comb begin
    fin_res                = '0;
    fin_res.dest_queue     = req_r.reply_queue;
    fin_res.entry_client   = req_r.client_id;
    fin_res.entry_category = req_r.category;
    fin_res.last           = 1'b1;
    case (req_r.command)
      psft_pkg::CMD_REG_PROD: begin
        fin_res.kind = (dup_r || !found_r) ? psft_pkg::KIND_NACK : psft_pkg::KIND_ACK;
      end
      psft_pkg::CMD_SUBSCRIBE: begin
        fin_res.kind = found_r ? psft_pkg::KIND_ACK : psft_pkg::KIND_NACK;
      end
      psft_pkg::CMD_UNSUB: begin
        fin_res.kind = psft_pkg::KIND_ACK;
      end
      default: begin
        fin_res.kind = psft_pkg::KIND_NACK;
      end
    endcase
    if (pend_v_r) begin
      fin_res      = pend_r;
      fin_res.last = 1'b1;
    end
  end

  assign fin_has = pend_v_r || (req_r.command != psft_pkg::CMD_NOTIFY);
  assign fin_go  = (state_r == ST_FIN) && (!fin_has || res_free);

  assign cmd_takes_scan = (in_req.command != psft_pkg::CMD_REG_CONS) &&
                          (in_req.command != psft_pkg::CMD_UNKNOWN);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    chk_v_nxt   = chk_v_r;
    chk_idx_nxt = chk_idx_r;
    found_nxt   = found_r;
    dup_nxt     = dup_r;
    slot_nxt    = slot_r;
    cnt_nxt     = cnt_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    case (state_r)
      ST_CLR: begin
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_CLR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req;
          idx_nxt    = '0;
          chk_v_nxt  = 1'b0;
          found_nxt  = 1'b0;
          dup_nxt    = 1'b0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          if (cmd_takes_scan) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FIN;
        end else if (!stall) begin
          if (eval) begin
            case (req_r.command)
              psft_pkg::CMD_REG_PROD: begin
                if (pe.valid && (pe.category == req_r.category)) begin
                  dup_nxt = 1'b1;
                end
                if (!pe.valid && !found_r) begin
                  found_nxt = 1'b1;
                  slot_nxt  = chk_idx_r;
                end
              end
              psft_pkg::CMD_SUBSCRIBE: begin
                if (!se.valid) begin
                  found_nxt = 1'b1;
                  slot_nxt  = chk_idx_r;
                end
              end
              psft_pkg::CMD_UNSUB: begin
                if (se.valid && (se.client == req_r.client_id) &&
                    (se.category == req_r.category)) begin
                  found_nxt = 1'b1;
                  slot_nxt  = chk_idx_r;
                end
              end
              default: begin
                if (hit_emit) begin
                  cnt_nxt    = cnt_r + CW'(1);
                  pend_v_nxt = 1'b1;
                  pend_nxt   = emit_res;
                end
              end
            endcase
          end
          chk_v_nxt = issue;
          if (issue) begin
            chk_idx_nxt = idx_r;
            idx_nxt     = idx_r + IW'(1);
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      idx_r    <= '0;
      chk_v_r  <= 1'b0;
      found_r  <= 1'b0;
      dup_r    <= 1'b0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      chk_v_r  <= chk_v_nxt;
      found_r  <= found_nxt;
      dup_r    <= dup_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    chk_idx_r <= chk_idx_nxt;
    slot_r    <= slot_nxt;
    pend_r    <= pend_nxt;
  end

  always_comb begin
    pw          = '0;
    pw.valid    = (state_r != ST_CLR);
    pw.owner    = req_r.client_id;
    pw.category = req_r.category;
    sw          = '0;
    sw.valid    = (state_r != ST_CLR) && (req_r.command == psft_pkg::CMD_SUBSCRIBE);
    sw.client   = req_r.client_id;
    sw.category = req_r.category;
    sw.queue    = req_r.reply_queue;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign prod_rd_en = issue && use_prod;
  assign sub_rd_en  = issue && !use_prod;
  assign prod_addr  = (state_r == ST_FIN) ? slot_r[PAW-1:0] : idx_r[PAW-1:0];
  assign sub_addr   = (state_r == ST_FIN) ? slot_r[SAW-1:0] : idx_r[SAW-1:0];
  assign prod_wdata = pw;
  assign sub_wdata  = sw;
  assign prod_we    = ((state_r == ST_CLR) && (idx_r < P_N)) ||
                      (fin_go && (req_r.command == psft_pkg::CMD_REG_PROD) &&
                       found_r && !dup_r);
  assign sub_we     = ((state_r == ST_CLR) && (idx_r < S_N)) ||
                      (fin_go && found_r &&
                       ((req_r.command == psft_pkg::CMD_SUBSCRIBE) ||
                        (req_r.command == psft_pkg::CMD_UNSUB)));

  assign res_push = (eval && hit_emit && pend_v_r && res_free) || (fin_go && fin_has);
  assign res_data = (state_r == ST_FIN) ? fin_res : pend_r;

endmodule

>>> hw/rtl/publish_subscribe_fanout_table_unit.sv
// Top level of the publish/subscribe fan-out table.
// After reset the block runs a clearing pass over both tables with in_stall
// high. It then takes one request at a time: register consumer and unknown
// commands read no table; every other request reads its table one entry per
// cycle through the memory's single port, unless the result side stalls.
// Register producer and list producers read the producer table, the others
// the subscriber table. Subscribe and unsubscribe end at the first free or
// matching slot. Stalls on the result side lengthen a request by the cycles
// it waits on them. Results of a request come in ascending slot order, at
// most 32, the final one marked with last.
module publish_subscribe_fanout_table_unit #(
  parameter int PRODUCER_SLOTS   = psft_pkg::PRODUCER_SLOTS_DEF,
  parameter int SUBSCRIBER_SLOTS = psft_pkg::SUBSCRIBER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psft_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output psft_pkg::out_res_t out_res
);

  localparam int PAW = (PRODUCER_SLOTS > 1) ? $clog2(PRODUCER_SLOTS) : 1;
  localparam int SAW = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;

  logic                        prod_rd_en;
  logic                        prod_we;
  logic [PAW-1:0]              prod_addr;
  logic [psft_pkg::PROD_W-1:0] prod_wdata;
  logic [psft_pkg::PROD_W-1:0] prod_rdata;
  logic                        sub_rd_en;
  logic                        sub_we;
  logic [SAW-1:0]              sub_addr;
  logic [psft_pkg::SUB_W-1:0]  sub_wdata;
  logic [psft_pkg::SUB_W-1:0]  sub_rdata;
  logic                        res_free;
  logic                        res_push;
  psft_pkg::out_res_t          res_data;

  psft_ram #(
    .DEPTH (PRODUCER_SLOTS),
    .AW    (PAW),
    .WIDTH (psft_pkg::PROD_W)
  ) u_prod_ram (
    .clk   (clk),
    .rd_en (prod_rd_en),
    .we    (prod_we),
    .addr  (prod_addr),
    .wdata (prod_wdata),
    .rdata (prod_rdata)
  );

  psft_ram #(
    .DEPTH (SUBSCRIBER_SLOTS),
    .AW    (SAW),
    .WIDTH (psft_pkg::SUB_W)
  ) u_sub_ram (
    .clk   (clk),
    .rd_en (sub_rd_en),
    .we    (sub_we),
    .addr  (sub_addr),
    .wdata (sub_wdata),
    .rdata (sub_rdata)
  );

  psft_seq #(
    .P   (PRODUCER_SLOTS),
    .S   (SUBSCRIBER_SLOTS),
    .PAW (PAW),
    .SAW (SAW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .prod_rd_en (prod_rd_en),
    .prod_we    (prod_we),
    .prod_addr  (prod_addr),
    .prod_wdata (prod_wdata),
    .prod_rdata (prod_rdata),
    .sub_rd_en  (sub_rd_en),
    .sub_we     (sub_we),
    .sub_addr   (sub_addr),
    .sub_wdata  (sub_wdata),
    .sub_rdata  (sub_rdata),
    .res_free   (res_free),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  psft_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .res_in    (res_data),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
